[hw/rtl/http_request_uri_recognizer_macros.svh]
// assertion macros for the request uri recognizer checker
`ifndef HTTP_REQUEST_URI_RECOGNIZER_MACROS_SVH
`define HTTP_REQUEST_URI_RECOGNIZER_MACROS_SVH

// same-cycle implication, disabled during reset
`define HRUR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hrur check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define HRUR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hrur check failed: next-cycle implication");

`endif

[hw/rtl/hrur_pkg.sv]
// shared types, state codes and character constants for the uri recognizer
`timescale 1ns / 1ps
`default_nettype none

package hrur_pkg;

  // default width of the byte position counter
  localparam int POSITION_BITS_DEF = 16;
  // width of the reported error position
  localparam int ERR_POS_W = 16;
  localparam int STATE_W = 5;

  // parser state codes
  typedef enum logic [STATE_W-1:0] {
    ST_START          = 5'd0,
    ST_G              = 5'd1,
    ST_GE             = 5'd2,
    ST_GET            = 5'd3,
    ST_P              = 5'd4,
    ST_PU             = 5'd5,
    ST_PUT            = 5'd6,
    ST_PO             = 5'd7,
    ST_POS            = 5'd8,
    ST_POST           = 5'd9,
    ST_SPACE          = 5'd10,
    ST_URI_START      = 5'd11,
    ST_SCHEME         = 5'd12,
    ST_SCHEME_COLON   = 5'd13,
    ST_REL_NOSCHEME   = 5'd14,
    ST_ROOTLESS       = 5'd15,
    ST_REL_PATH       = 5'd16,
    ST_SLASH_SLASH    = 5'd17,
    ST_AUTHORITY      = 5'd18,
    ST_REL_PATH_SLASH = 5'd19,
    ST_SEG_SLASH      = 5'd20,
    ST_ROOTLESS_SLASH = 5'd21,
    ST_SEGMENT        = 5'd22,
    ST_QUERY          = 5'd23,
    ST_FRAGMENT       = 5'd24,
    ST_ERROR          = 5'd25
  } state_t;

  // character class flags of one byte
  typedef struct packed {
    logic alpha;
    logic alnum;
    logic unreserved;
    logic subdelim;
    logic pchar_nc;
    logic pchar;
    logic scheme_ch;
    logic auth_ch;
    logic is_space;
    logic is_colon;
    logic is_slash;
    logic is_question;
    logic is_hash;
  } char_class_t;

  // method letters and delimiters
  localparam logic [7:0] CH_G        = 8'h47;
  localparam logic [7:0] CH_P        = 8'h50;
  localparam logic [7:0] CH_E        = 8'h45;
  localparam logic [7:0] CH_T        = 8'h54;
  localparam logic [7:0] CH_U        = 8'h55;
  localparam logic [7:0] CH_O        = 8'h4F;
  localparam logic [7:0] CH_S        = 8'h53;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_HASH     = 8'h23;

endpackage

`default_nettype wire

[hw/rtl/http_request_uri_recognizer.sv]
// top level of the byte-serial http request line and uri recognizer
`timescale 1ns / 1ps
`default_nettype none

// Takes one byte of request text per transaction and checks the method
// (GET, PUT or POST), optional spaces and an rfc 3986 style uri. Every
// accepted byte gives exactly one registered result transaction, with
// the state code (25 = error), a sticky error flag with the index of the
// first rejected byte, and on the last byte the pass/fail verdict. A byte
// can be accepted in every cycle: the character decode and the state
// transition sit between the parser state registers and the result register,
// and the input stays ready unless a held result is not taken. first_byte
// restarts state, position and error; the position counter saturates.

module http_request_uri_recognizer
  import hrur_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // byte input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 first_byte,
  input  logic                 last_byte,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATE_W-1:0]   parse_state,
  output logic                 error_seen,
  output logic [ERR_POS_W-1:0] error_position,
  output logic                 request_done,
  output logic                 request_ok
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  // parser state
  state_t                   state;
  logic [POSITION_BITS-1:0] position;
  logic                     err_flag;
  logic [POSITION_BITS-1:0] err_index;

  // state seen by this byte after an optional restart
  state_t                   cur_state;
  logic [POSITION_BITS-1:0] cur_pos;
  logic                     cur_err;
  logic [POSITION_BITS-1:0] cur_idx;

  state_t                   state_next;
  logic [POSITION_BITS-1:0] position_next;
  logic                     err_flag_next;
  logic [POSITION_BITS-1:0] err_index_next;
  logic [POSITION_BITS+ERR_POS_W-1:0] idx_ext;

  char_class_t cls;
  logic        in_fire;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  // restart on the first byte of a request
  always_comb begin
    cur_state = first_byte ? ST_START : state;
    cur_pos   = first_byte ? '0 : position;
    cur_err   = first_byte ? 1'b0 : err_flag;
    cur_idx   = first_byte ? '0 : err_index;
  end

  hrur_char_class u_char_class (
    .data_byte (data_byte),
    .cls       (cls)
  );

  hrur_next_state u_next_state (
    .cur_state (cur_state),
    .data_byte (data_byte),
    .cls       (cls),
    .nxt_state (state_next)
  );

  // error capture and saturating position
  always_comb begin
    err_flag_next  = cur_err || (state_next == ST_ERROR);
    err_index_next = (!cur_err && (state_next == ST_ERROR)) ? cur_pos : cur_idx;
    position_next  = (cur_pos == POS_MAX) ? cur_pos : cur_pos + 1'b1;
    idx_ext        = {{ERR_POS_W{1'b0}}, err_index_next};
  end

  // parser state registers and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_START;
      position  <= '0;
      err_flag  <= 1'b0;
      err_index <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        state     <= state_next;
        position  <= position_next;
        err_flag  <= err_flag_next;
        err_index <= err_index_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      parse_state    <= state_next;
      error_seen     <= err_flag_next;
      error_position <= err_flag_next ? idx_ext[ERR_POS_W-1:0] : '0;
      request_done   <= last_byte;
      request_ok     <= last_byte && !err_flag_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/hrur_char_class.sv]
// character class decoder for one request byte
`timescale 1ns / 1ps
`default_nettype none

module hrur_char_class
  import hrur_pkg::*;
(
  input  logic [7:0]  data_byte,
  output char_class_t cls
);

  logic alpha;
  logic digit;
  logic unreserved;
  logic subdelim;
  logic pchar_nc;

  // basic letter, digit and rfc 3986 sets
  always_comb begin
    alpha      = data_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    digit      = data_byte inside {[8'h30:8'h39]};
    // '-' '.' '_' '~'
    unreserved = alpha | digit | (data_byte inside {8'h2D, 8'h2E, 8'h5F, 8'h7E});
    // ! $ & ' ( ) * + , ; =
    subdelim   = data_byte inside {8'h21, 8'h24, [8'h26:8'h2C], 8'h3B, 8'h3D};
    // lone percent counts as escaped, plus '@'
    pchar_nc   = unreserved | subdelim | (data_byte inside {8'h25, 8'h40});
  end

  // derived classes and single delimiters
  always_comb begin
    cls.alpha       = alpha;
    cls.alnum       = alpha | digit;
    cls.unreserved  = unreserved;
    cls.subdelim    = subdelim;
    cls.pchar_nc    = pchar_nc;
    cls.is_colon    = data_byte == CH_COLON;
    cls.pchar       = pchar_nc | (data_byte == CH_COLON);
    // scheme chars: alnum, '+', '-', '.'
    cls.scheme_ch   = alpha | digit | (data_byte inside {8'h2B, 8'h2D, 8'h2E});
    // authority adds ':' '[' ']' to the path chars
    cls.auth_ch     = pchar_nc | (data_byte inside {CH_COLON, 8'h5B, 8'h5D});
    cls.is_space    = data_byte == CH_SPACE;
    cls.is_slash    = data_byte == CH_SLASH;
    cls.is_question = data_byte == CH_QUESTION;
    cls.is_hash     = data_byte == CH_HASH;
  end

endmodule

`default_nettype wire

[hw/rtl/hrur_next_state.sv]
// transition function of the method and uri automaton
`timescale 1ns / 1ps
`default_nettype none

module hrur_next_state
  import hrur_pkg::*;
(
  input  state_t      cur_state,
  input  logic [7:0]  data_byte,
  input  char_class_t cls,
  output state_t      nxt_state
);

  state_t uri_start;

  // first byte of the uri
  always_comb begin
    if (cls.alpha) begin
      uri_start = ST_SCHEME;
    end else if (cls.pchar_nc) begin
      uri_start = ST_REL_NOSCHEME;
    end else if (cls.is_slash) begin
      uri_start = ST_REL_PATH;
    end else if (cls.is_question) begin
      uri_start = ST_QUERY;
    end else if (cls.is_hash) begin
      uri_start = ST_FRAGMENT;
    end else begin
      uri_start = ST_ERROR;
    end
  end

  // next state per current state
  always_comb begin
    nxt_state = ST_ERROR;
    case (cur_state)
      ST_START: begin
        if (data_byte == CH_G) nxt_state = ST_G;
        else if (data_byte == CH_P) nxt_state = ST_P;
      end
      ST_G: if (data_byte == CH_E) nxt_state = ST_GE;
      ST_GE: if (data_byte == CH_T) nxt_state = ST_GET;
      ST_P: begin
        if (data_byte == CH_U) nxt_state = ST_PU;
        else if (data_byte == CH_O) nxt_state = ST_PO;
      end
      ST_PU: if (data_byte == CH_T) nxt_state = ST_PUT;
      ST_PO: if (data_byte == CH_S) nxt_state = ST_POS;
      ST_POS: if (data_byte == CH_T) nxt_state = ST_POST;
      ST_GET, ST_PUT, ST_POST, ST_SPACE: begin
        nxt_state = cls.is_space ? ST_SPACE : uri_start;
      end
      ST_URI_START: nxt_state = uri_start;
      ST_REL_NOSCHEME: begin
        if (cls.pchar_nc) nxt_state = ST_REL_NOSCHEME;
        else if (cls.is_slash) nxt_state = ST_REL_PATH_SLASH;
      end
      ST_ROOTLESS: begin
        if (cls.pchar) nxt_state = ST_ROOTLESS;
        else if (cls.is_slash) nxt_state = ST_ROOTLESS_SLASH;
      end
      ST_SCHEME: begin
        if (cls.scheme_ch) nxt_state = ST_SCHEME;
        else if (cls.is_colon) nxt_state = ST_SCHEME_COLON;
        else if (cls.pchar_nc) nxt_state = ST_REL_NOSCHEME;
        else if (cls.is_slash) nxt_state = ST_SLASH_SLASH;
      end
      ST_SCHEME_COLON: begin
        if (cls.is_slash) nxt_state = ST_SLASH_SLASH;
        else if (cls.pchar) nxt_state = ST_ROOTLESS;
        else if (cls.is_question) nxt_state = ST_QUERY;
        else if (cls.is_hash) nxt_state = ST_FRAGMENT;
      end
      ST_REL_PATH, ST_SLASH_SLASH: begin
        if (cls.is_slash) nxt_state = ST_AUTHORITY;
        else if (cls.pchar) nxt_state = ST_SEGMENT;
      end
      ST_AUTHORITY: begin
        if (cls.auth_ch) nxt_state = ST_AUTHORITY;
        else if (cls.is_question) nxt_state = ST_QUERY;
        else if (cls.is_hash) nxt_state = ST_FRAGMENT;
        else if (cls.is_slash) nxt_state = ST_SEG_SLASH;
      end
      ST_REL_PATH_SLASH, ST_SEG_SLASH, ST_ROOTLESS_SLASH: begin
        if (cls.pchar) nxt_state = ST_SEGMENT;
      end
      ST_SEGMENT: begin
        if (cls.pchar) nxt_state = ST_SEGMENT;
        else if (cls.is_slash) nxt_state = ST_SEG_SLASH;
        else if (cls.is_question) nxt_state = ST_QUERY;
        else if (cls.is_hash) nxt_state = ST_FRAGMENT;
      end
      ST_QUERY: begin
        if (cls.is_question || cls.is_slash || cls.pchar) nxt_state = ST_QUERY;
        else if (cls.is_hash) nxt_state = ST_FRAGMENT;
      end
      ST_FRAGMENT: begin
        if (cls.is_question || cls.is_slash || cls.pchar) nxt_state = ST_FRAGMENT;
      end
      default: nxt_state = ST_ERROR;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/hrur_checker.sv]
// port-level checker for the uri recognizer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "http_request_uri_recognizer_macros.svh"

module hrur_checker
  import hrur_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [STATE_W-1:0]   parse_state,
  input wire logic                 error_seen,
  input wire logic [ERR_POS_W-1:0] error_position,
  input wire logic                 request_done,
  input wire logic                 request_ok
);

  // every accepted byte yields a result in the next cycle
  `HRUR_ASSERT_NEXT(a_byte_gives_result, clk, rst, in_valid && in_ready, out_valid)

  // a pass verdict only on a clean last byte
  `HRUR_ASSERT_IMPLY(a_ok_clean, clk, rst, out_valid && request_ok, request_done && !error_seen)

  // error state always carries the sticky flag
  `HRUR_ASSERT_IMPLY(a_error_flagged, clk, rst, out_valid && parse_state == ST_ERROR, error_seen)

  // no error position without an error
  `HRUR_ASSERT_IMPLY(a_pos_zero, clk, rst, out_valid && !error_seen, error_position == '0)

  // a stalled result holds
  `HRUR_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(parse_state) && $stable(error_position))

endmodule

bind http_request_uri_recognizer hrur_checker u_hrur_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .parse_state    (parse_state),
  .error_seen     (error_seen),
  .error_position (error_position),
  .request_done   (request_done),
  .request_ok     (request_ok)
);

`default_nettype wire

[tb/http_request_uri_recognizer_test.sv]
// self-checking testbench for the http request line and uri recognizer
`timescale 1ns / 1ps

module http_request_uri_recognizer_test;
  import hrur_pkg::*;

  // one request byte with an optional hand-written expectation
  typedef struct packed {
    logic [7:0]           ch;
    logic                 first;
    logic                 last;
    logic                 typed;
    state_t               st;
    logic                 err;
    logic [ERR_POS_W-1:0] epos;
  } byte_row_t;

  // one result transaction
  typedef struct packed {
    logic [STATE_W-1:0]   st;
    logic                 err;
    logic [ERR_POS_W-1:0] epos;
    logic                 done;
    logic                 ok;
  } verdict_t;

  localparam logic [POSITION_BITS_DEF-1:0] POS_LIMIT = '1;
  localparam int PHASE_BYTES = 460;

  // directed requests: methods, spaces, authority and scheme uris, errors, extremes
  localparam byte_row_t DIRECTED [27] = '{
    '{"G", 1'b1, 1'b0, 1'b1, ST_G, 1'b0, 16'd0},
    '{"E", 1'b0, 1'b0, 1'b1, ST_GE, 1'b0, 16'd0},
    '{"T", 1'b0, 1'b0, 1'b1, ST_GET, 1'b0, 16'd0},
    '{" ", 1'b0, 1'b0, 1'b0, ST_START, 1'b0, 16'd0},
    '{" ", 1'b0, 1'b0, 1'b0, ST_START, 1'b0, 16'd0},
    '{"/", 1'b0, 1'b0, 1'b0, ST_START, 1'b0, 16'd0},
    '{"/", 1'b0, 1'b0, 1'b0, ST_START, 1'b0, 16'd0},
    '{"[", 1'b0, 1'b0, 1'b0, ST_START, 1'b0, 16'd0},
    '{"?", 1'b0, 1'b0, 1'b0, ST_START, 1'b0, 16'd0},
    '{"#", 1'b0, 1'b1, 1'b0, ST_START, 1'b0, 16'd0},
    '{"P", 1'b1, 1'b0, 1'b1, ST_P, 1'b0, 16'd0},
    '{"O", 1'b0, 1'b0, 1'b0, ST_START, 1'b0, 16'd0},
    '{"S", 1'b0, 1'b0, 1'b0, ST_START, 1'b0, 16'd0},
    '{"T", 1'b0, 1'b0, 1'b0, ST_START, 1'b0, 16'd0},
    '{"h", 1'b0, 1'b0, 1'b0, ST_START, 1'b0, 16'd0},
    '{":", 1'b0, 1'b0, 1'b0, ST_START, 1'b0, 16'd0},
    '{"x", 1'b0, 1'b0, 1'b0, ST_START, 1'b0, 16'd0},
    '{"/", 1'b0, 1'b1, 1'b0, ST_START, 1'b0, 16'd0},
    '{"P", 1'b1, 1'b0, 1'b1, ST_P, 1'b0, 16'd0},
    '{"U", 1'b0, 1'b0, 1'b0, ST_START, 1'b0, 16'd0},
    '{"T", 1'b0, 1'b0, 1'b0, ST_START, 1'b0, 16'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b1, ST_ERROR, 1'b1, 16'd3},
    '{8'h00, 1'b0, 1'b1, 1'b1, ST_ERROR, 1'b1, 16'd3},
    '{8'h00, 1'b1, 1'b1, 1'b1, ST_ERROR, 1'b1, 16'd0},
    '{"G", 1'b1, 1'b0, 1'b0, ST_START, 1'b0, 16'd0},
    '{"T", 1'b0, 1'b1, 1'b0, ST_START, 1'b0, 16'd0},
    '{"%", 1'b0, 1'b1, 1'b0, ST_START, 1'b0, 16'd0}
  };

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           data_byte = 8'h00;
  logic                 first_byte = 1'b0;
  logic                 last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATE_W-1:0]   parse_state;
  logic                 error_seen;
  logic [ERR_POS_W-1:0] error_position;
  logic                 request_done;
  logic                 request_ok;

  // bytes waiting to be sent, results waiting to arrive
  byte_row_t byte_backlog[$];
  verdict_t  expected_verdicts[$];
  byte_row_t cur_byte = '0;
  int        bytes_in_flight = 0;
  int        bytes_queued = 0;
  int        error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // character pools for the request generator
  string method_chars = "GETPUOS";
  string uri_chars = "azAZ09-._~!$&'()*+,;=%@:/?#[] //??##::";

  // tracked parser state
  state_t                       trk_state = ST_START;
  logic [POSITION_BITS_DEF-1:0] trk_pos = '0;
  logic                         trk_err = 1'b0;
  logic [POSITION_BITS_DEF-1:0] trk_err_idx = '0;

  http_request_uri_recognizer dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .first_byte     (first_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .parse_state    (parse_state),
    .error_seen     (error_seen),
    .error_position (error_position),
    .request_done   (request_done),
    .request_ok     (request_ok)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // character classes
  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_alnum(input logic [7:0] c);
    return is_alpha(c) || (c >= "0" && c <= "9");
  endfunction

  function automatic bit is_unreserved(input logic [7:0] c);
    return is_alnum(c) || c == "-" || c == "." || c == "_" || c == "~";
  endfunction

  function automatic bit is_subdelim(input logic [7:0] c);
    return c == "!" || c == "$" || c == "&" || c == "'" || c == "(" || c == ")" ||
           c == "*" || c == "+" || c == "," || c == ";" || c == "=";
  endfunction

  // path character without colon; a lone percent counts as escaped
  function automatic bit is_seg_char(input logic [7:0] c);
    return is_unreserved(c) || is_subdelim(c) || c == "%" || c == "@";
  endfunction

  function automatic bit is_path_char(input logic [7:0] c);
    return is_seg_char(c) || c == CH_COLON;
  endfunction

  // first byte of the uri
  function automatic state_t uri_entry(input logic [7:0] c);
    if (is_alpha(c)) return ST_SCHEME;
    if (is_seg_char(c)) return ST_REL_NOSCHEME;
    if (c == CH_SLASH) return ST_REL_PATH;
    if (c == CH_QUESTION) return ST_QUERY;
    if (c == CH_HASH) return ST_FRAGMENT;
    return ST_ERROR;
  endfunction

  // state transition for one byte
  function automatic state_t next_parse_state(input state_t s, input logic [7:0] c);
    case (s)
      ST_START: return c == CH_G ? ST_G : (c == CH_P ? ST_P : ST_ERROR);
      ST_G:     return c == CH_E ? ST_GE : ST_ERROR;
      ST_GE:    return c == CH_T ? ST_GET : ST_ERROR;
      ST_P:     return c == CH_U ? ST_PU : (c == CH_O ? ST_PO : ST_ERROR);
      ST_PU:    return c == CH_T ? ST_PUT : ST_ERROR;
      ST_PO:    return c == CH_S ? ST_POS : ST_ERROR;
      ST_POS:   return c == CH_T ? ST_POST : ST_ERROR;
      ST_GET, ST_PUT, ST_POST, ST_SPACE:
        return c == CH_SPACE ? ST_SPACE : uri_entry(c);
      ST_URI_START: return uri_entry(c);
      ST_REL_NOSCHEME: begin
        if (is_seg_char(c)) return ST_REL_NOSCHEME;
        return c == CH_SLASH ? ST_REL_PATH_SLASH : ST_ERROR;
      end
      ST_ROOTLESS: begin
        if (is_path_char(c)) return ST_ROOTLESS;
        return c == CH_SLASH ? ST_ROOTLESS_SLASH : ST_ERROR;
      end
      ST_SCHEME: begin
        if (is_alnum(c) || c == "+" || c == "-" || c == ".") return ST_SCHEME;
        if (c == CH_COLON) return ST_SCHEME_COLON;
        if (is_seg_char(c)) return ST_REL_NOSCHEME;
        return c == CH_SLASH ? ST_SLASH_SLASH : ST_ERROR;
      end
      ST_SCHEME_COLON: begin
        if (c == CH_SLASH) return ST_SLASH_SLASH;
        if (is_path_char(c)) return ST_ROOTLESS;
        if (c == CH_QUESTION) return ST_QUERY;
        return c == CH_HASH ? ST_FRAGMENT : ST_ERROR;
      end
      ST_REL_PATH, ST_SLASH_SLASH: begin
        if (c == CH_SLASH) return ST_AUTHORITY;
        return is_path_char(c) ? ST_SEGMENT : ST_ERROR;
      end
      ST_AUTHORITY: begin
        if (is_path_char(c) || c == "[" || c == "]") return ST_AUTHORITY;
        if (c == CH_QUESTION) return ST_QUERY;
        if (c == CH_HASH) return ST_FRAGMENT;
        return c == CH_SLASH ? ST_SEG_SLASH : ST_ERROR;
      end
      ST_REL_PATH_SLASH, ST_SEG_SLASH, ST_ROOTLESS_SLASH:
        return is_path_char(c) ? ST_SEGMENT : ST_ERROR;
      ST_SEGMENT: begin
        if (is_path_char(c)) return ST_SEGMENT;
        if (c == CH_SLASH) return ST_SEG_SLASH;
        if (c == CH_QUESTION) return ST_QUERY;
        return c == CH_HASH ? ST_FRAGMENT : ST_ERROR;
      end
      ST_QUERY: begin
        if (c == CH_QUESTION || c == CH_SLASH || is_path_char(c)) return ST_QUERY;
        return c == CH_HASH ? ST_FRAGMENT : ST_ERROR;
      end
      ST_FRAGMENT:
        return (c == CH_QUESTION || c == CH_SLASH || is_path_char(c)) ?
               ST_FRAGMENT : ST_ERROR;
      default: return ST_ERROR;
    endcase
  endfunction

  // advance the tracked request by one byte and give its verdict
  function automatic verdict_t track_request_byte(input byte_row_t b);
    verdict_t v;
    if (b.first) begin
      trk_state = ST_START;
      trk_pos = '0;
      trk_err = 1'b0;
      trk_err_idx = '0;
    end
    trk_state = next_parse_state(trk_state, b.ch);
    if (trk_state == ST_ERROR && !trk_err) begin
      trk_err = 1'b1;
      trk_err_idx = trk_pos;
    end
    if (trk_pos != POS_LIMIT) trk_pos = trk_pos + 1'b1;
    v.st = trk_state;
    v.err = trk_err;
    v.epos = trk_err ? trk_err_idx[ERR_POS_W-1:0] : '0;
    v.done = b.last;
    v.ok = b.last && !trk_err;
    return v;
  endfunction

  task automatic push_row(input byte_row_t r);
    byte_backlog.push_back(r);
    bytes_in_flight++;
    bytes_queued++;
  endtask

  task automatic push_byte(input logic [7:0] c, input logic first, input logic last);
    push_row('{c, first, last, 1'b0, ST_START, 1'b0, 16'd0});
  endtask

  // mostly characters that fit the current state, now and then any byte
  function automatic logic [7:0] pick_char(input state_t s);
    if ($urandom_range(19) == 0) return 8'($urandom_range(255));
    if (s inside {ST_START, ST_G, ST_GE, ST_P, ST_PU, ST_PO, ST_POS})
      return method_chars[$urandom_range(method_chars.len() - 1)];
    return uri_chars[$urandom_range(uri_chars.len() - 1)];
  endfunction

  // one request built by a guided walk, sometimes broken or left open
  task automatic queue_request();
    state_t     walk;
    logic [7:0] c;
    int         len;
    int         cut;
    int         tries;
    bit         broken;
    bit         open_start;
    bit         open_end;
    walk = ST_START;
    len = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(3, 24);
    broken = ($urandom_range(9) == 0);
    cut = $urandom_range(len - 1);
    open_start = ($urandom_range(19) == 0);
    open_end = ($urandom_range(19) == 0);
    for (int i = 0; i < len; i++) begin
      if (broken && i == cut) begin
        c = 8'($urandom_range(255));
      end else begin
        tries = 0;
        do begin
          c = pick_char(walk);
          tries++;
        end while (next_parse_state(walk, c) == ST_ERROR && tries < 12);
      end
      walk = next_parse_state(walk, c);
      push_byte(c, i == 0 && !open_start, i == len - 1 && !open_end);
    end
  endtask

  task automatic wait_for_drain();
    do @(negedge clk); while (bytes_in_flight != 0);
  endtask

  // byte sender: predict on each accepted transaction, then offer the next byte
  always @(posedge clk) begin : feed_bytes
    verdict_t  predicted;
    byte_row_t nxt;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predicted = track_request_byte(cur_byte);
        if (cur_byte.typed)
          predicted = '{cur_byte.st, cur_byte.err, cur_byte.epos, cur_byte.last,
                        cur_byte.last && !cur_byte.err};
        expected_verdicts.push_back(predicted);
      end
      if (!in_valid || in_ready) begin
        if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = byte_backlog.pop_front();
          cur_byte <= nxt;
          data_byte <= nxt.ch;
          first_byte <= nxt.first;
          last_byte <= nxt.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic flag_field(input string name, input logic [15:0] want,
                            input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // result receiver: random stalls, field by field compare
  always @(posedge clk) begin : take_verdicts
    verdict_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result transaction with nothing expected, state %0d",
                   $time, parse_state);
          error_count++;
        end else begin
          want = expected_verdicts.pop_front();
          bytes_in_flight--;
          flag_field("parse_state", want.st, parse_state);
          flag_field("error_seen", want.err, error_seen);
          flag_field("error_position", want.epos, error_position);
          flag_field("request_done", want.done, request_done);
          flag_field("request_ok", want.ok, request_ok);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // main sequence
  initial begin : run_phases
    int unsigned send_plan [4];
    int unsigned recv_plan [4];
    int          target;
    send_plan = '{0, 83, 0, 10};
    recv_plan = '{0, 0, 83, 10};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    for (int i = 0; i < $size(DIRECTED); i++) push_row(DIRECTED[i]);
    wait_for_drain();

    // random requests under each idling pattern
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_plan[p];
      recv_stall_pct = recv_plan[p];
      target = bytes_queued + PHASE_BYTES;
      while (bytes_queued < target) begin
        if ($urandom_range(99) < 6)
          push_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        else
          queue_request();
      end
      wait_for_drain();
    end

    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
